// ===== rtl/sgi_pkg.sv =====
// Shared constants for the segment intersection unit.
`default_nettype none
package sgi_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int OUT_BITS       = 32;
endpackage
`default_nettype wire

// ===== rtl/sgi_front.sv =====
// Front pipeline: case selection, cross products, denominator and sign normalization.
`default_nettype none
module sgi_front #(
    parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic signed [COORD_BITS-1:0]    ax,
    input  logic signed [COORD_BITS-1:0]    ay,
    input  logic signed [COORD_BITS-1:0]    bx,
    input  logic signed [COORD_BITS-1:0]    by_coord,
    input  logic signed [COORD_BITS-1:0]    cx,
    input  logic signed [COORD_BITS-1:0]    cy,
    input  logic signed [COORD_BITS-1:0]    dx,
    input  logic signed [COORD_BITS-1:0]    dy,
    output logic                            out_valid,
    output logic                            out_bad,
    output logic signed [2*COORD_BITS+4:0]  den,
    output logic signed [2*COORD_BITS+4:0]  tn,
    output logic [12*COORD_BITS+3:0]        geo
);
    localparam int C   = COORD_BITS;
    localparam int DFW = C + 2;
    localparam int PW  = 2 * DFW;
    localparam int DW  = PW + 1;
    localparam int GW  = 10 * C + 2 * DFW;
    localparam logic signed [DFW-1:0] ONE = DFW'(1);

    logic signed [DFW-1:0] rx, ry, qx, qy, wx, wy;
    logic                  vab, vcd;
    logic signed [DFW-1:0] op_a_next [4];
    logic signed [DFW-1:0] op_b_next [4];
    logic signed [DFW-1:0] xr_next, yr_next;
    logic signed [C-1:0]   xa_next, ya_next;
    logic signed [C-1:0]   lo_next [4];
    logic signed [C-1:0]   hi_next [4];
    logic [GW-1:0]         geo_next;

    logic                  vld_a_reg, vld_b_reg, vld_c_reg, vld_d_reg;
    logic                  both_a_reg, both_b_reg, both_c_reg, bad_d_reg;
    logic signed [DFW-1:0] op_a_reg [4];
    logic signed [DFW-1:0] op_b_reg [4];
    logic signed [PW-1:0]  prod_reg [4];
    logic signed [DW-1:0]  tn_c_reg, den_c_reg, tn_d_reg, den_d_reg;
    logic [GW-1:0]         geo_a_reg, geo_b_reg, geo_c_reg, geo_d_reg;

    always_comb begin
        rx  = DFW'(bx) - DFW'(ax);
        ry  = DFW'(by_coord) - DFW'(ay);
        qx  = DFW'(dx) - DFW'(cx);
        qy  = DFW'(dy) - DFW'(cy);
        wx  = DFW'(cx) - DFW'(ax);
        wy  = DFW'(cy) - DFW'(ay);
        vab = (ax == bx);
        vcd = (cx == dx);

        op_a_next[0] = wx;  op_b_next[0] = qy;
        op_a_next[1] = wy;  op_b_next[1] = qx;
        op_a_next[2] = rx;  op_b_next[2] = qy;
        op_a_next[3] = ry;  op_b_next[3] = qx;
        xa_next = ax;
        xr_next = rx;
        ya_next = ay;
        yr_next = ry;
        if (vab) begin
            op_a_next[1] = DFW'(cy);
            op_a_next[2] = '0;   op_b_next[2] = '0;
            op_a_next[3] = ONE;
            xr_next = '0;
            ya_next = '0;
            yr_next = ONE;
        end else if (vcd) begin
            op_a_next[0] = -ry;  op_b_next[0] = wx;
            op_a_next[1] = DFW'(ay);  op_b_next[1] = rx;
            op_a_next[2] = '0;   op_b_next[2] = '0;
            op_a_next[3] = rx;   op_b_next[3] = ONE;
            xa_next = cx;
            xr_next = '0;
            ya_next = '0;
            yr_next = ONE;
        end

        lo_next[0] = (ax < bx) ? ax : bx;
        hi_next[0] = (ax < bx) ? bx : ax;
        lo_next[1] = (cx < dx) ? cx : dx;
        hi_next[1] = (cx < dx) ? dx : cx;
        lo_next[2] = (ay < by_coord) ? ay : by_coord;
        hi_next[2] = (ay < by_coord) ? by_coord : ay;
        lo_next[3] = (cy < dy) ? cy : dy;
        hi_next[3] = (cy < dy) ? dy : cy;

        geo_next = {hi_next[3], hi_next[2], hi_next[1], hi_next[0],
                    lo_next[3], lo_next[2], lo_next[1], lo_next[0],
                    yr_next, xr_next, ya_next, xa_next};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
            vld_c_reg <= 1'b0;
            vld_d_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
            vld_c_reg <= vld_b_reg;
            vld_d_reg <= vld_c_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < 4; i++) begin
                op_a_reg[i] <= op_a_next[i];
                op_b_reg[i] <= op_b_next[i];
                prod_reg[i] <= op_a_reg[i] * op_b_reg[i];
            end
            both_a_reg <= vab && vcd;
            geo_a_reg  <= geo_next;

            both_b_reg <= both_a_reg;
            geo_b_reg  <= geo_a_reg;

            tn_c_reg   <= DW'(prod_reg[0]) - DW'(prod_reg[1]);
            den_c_reg  <= DW'(prod_reg[2]) - DW'(prod_reg[3]);
            both_c_reg <= both_b_reg;
            geo_c_reg  <= geo_b_reg;

            tn_d_reg   <= den_c_reg[DW-1] ? -tn_c_reg : tn_c_reg;
            den_d_reg  <= den_c_reg[DW-1] ? -den_c_reg : den_c_reg;
            bad_d_reg  <= both_c_reg || (den_c_reg == '0);
            geo_d_reg  <= geo_c_reg;
        end
    end

    assign out_valid = vld_d_reg;
    assign out_bad   = bad_d_reg;
    assign den       = den_d_reg;
    assign tn        = tn_d_reg;
    assign geo       = geo_d_reg;
endmodule
`default_nettype wire

// ===== rtl/sgi_solve.sv =====
// Solve pipeline: crossing numerators, exact box test and magnitudes for division.
`default_nettype none
module sgi_solve #(
    parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            en,
    input  logic                            in_valid,
    input  logic                            in_bad,
    input  logic signed [2*COORD_BITS+4:0]  den,
    input  logic signed [2*COORD_BITS+4:0]  tn,
    input  logic [12*COORD_BITS+3:0]        geo,
    output logic                            out_valid,
    output logic                            out_hit,
    output logic                            out_neg_x,
    output logic                            out_neg_y,
    output logic [3*COORD_BITS+7:0]         out_mag_x,
    output logic [3*COORD_BITS+7:0]         out_mag_y,
    output logic [2*COORD_BITS+4:0]         out_den
);
    localparam int C   = COORD_BITS;
    localparam int DFW = C + 2;
    localparam int DW  = 2 * DFW + 1;
    localparam int NW  = DW + DFW + 1;
    localparam int BW  = C + DW;

    logic signed [C-1:0]   xa, ya;
    logic signed [DFW-1:0] xr, yr;
    logic signed [C-1:0]   lim [8];
    logic                  inb [4];
    logic                  all_in;

    logic                  vld_e_reg, vld_f_reg, vld_g_reg;
    logic                  bad_e_reg, bad_f_reg, hit_g_reg;
    logic signed [NW-1:0]  px1_reg, px2_reg, py1_reg, py2_reg;
    logic signed [BW-1:0]  bnd_e_reg [8];
    logic signed [BW-1:0]  bnd_f_reg [8];
    logic signed [DW-1:0]  den_e_reg, den_f_reg, den_g_reg;
    logic signed [NW-1:0]  nx_reg, ny_reg;
    logic                  neg_x_reg, neg_y_reg;
    logic [NW-1:0]         mag_x_reg, mag_y_reg;

    always_comb begin
        xa = geo[C-1:0];
        ya = geo[2*C-1:C];
        xr = geo[2*C+DFW-1:2*C];
        yr = geo[2*C+2*DFW-1:2*C+DFW];
        for (int i = 0; i < 8; i++) begin
            lim[i] = geo[2*C+2*DFW+i*C +: C];
        end
        for (int i = 0; i < 4; i++) begin
            inb[i] = (i < 2)
                ? (NW'(bnd_f_reg[i]) <= nx_reg) && (nx_reg <= NW'(bnd_f_reg[4+i]))
                : (NW'(bnd_f_reg[i]) <= ny_reg) && (ny_reg <= NW'(bnd_f_reg[4+i]));
        end
        all_in = inb[0] && inb[1] && inb[2] && inb[3];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_e_reg <= 1'b0;
            vld_f_reg <= 1'b0;
            vld_g_reg <= 1'b0;
        end else if (en) begin
            vld_e_reg <= in_valid;
            vld_f_reg <= vld_e_reg;
            vld_g_reg <= vld_f_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            px1_reg   <= xa * den;
            px2_reg   <= tn * xr;
            py1_reg   <= ya * den;
            py2_reg   <= tn * yr;
            for (int i = 0; i < 8; i++) begin
                bnd_e_reg[i] <= lim[i] * den;
                bnd_f_reg[i] <= bnd_e_reg[i];
            end
            bad_e_reg <= in_bad;
            den_e_reg <= den;

            nx_reg    <= px1_reg + px2_reg;
            ny_reg    <= py1_reg + py2_reg;
            bad_f_reg <= bad_e_reg;
            den_f_reg <= den_e_reg;

            hit_g_reg <= !bad_f_reg && all_in;
            neg_x_reg <= nx_reg[NW-1];
            neg_y_reg <= ny_reg[NW-1];
            mag_x_reg <= nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
            mag_y_reg <= ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
            den_g_reg <= den_f_reg;
        end
    end

    assign out_valid = vld_g_reg;
    assign out_hit   = hit_g_reg;
    assign out_neg_x = neg_x_reg;
    assign out_neg_y = neg_y_reg;
    assign out_mag_x = mag_x_reg;
    assign out_mag_y = mag_y_reg;
    assign out_den   = den_g_reg;
endmodule
`default_nettype wire

// ===== rtl/sgi_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module sgi_div #(
    parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sgi_pkg::FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [3*COORD_BITS+7:0]           mag,
    input  logic [2*COORD_BITS+4:0]           den,
    output logic [COORD_BITS+FRAC_BITS-1:0]   quo
);
    localparam int C    = COORD_BITS;
    localparam int DW   = 2 * C + 5;
    localparam int NW   = 3 * C + 8;
    localparam int QB   = C + FRAC_BITS;
    localparam int NUMW = NW + FRAC_BITS;

    logic [NUMW-1:0] num;
    logic [DW-1:0]   rem_reg [QB];
    logic [QB-1:0]   low_reg [QB];
    logic [DW-1:0]   den_reg [QB];
    logic [QB-1:0]   q_reg   [QB];

    assign num = {mag, {FRAC_BITS{1'b0}}};

    for (genvar j = 0; j < QB; j++) begin : g_step
        logic [DW-1:0] rem_in;
        logic [QB-1:0] low_in;
        logic [DW-1:0] den_in;
        logic [QB-1:0] q_in;
        logic [DW:0]   trial;
        logic          ge;

        if (j == 0) begin : g_first
            assign rem_in = num[QB+DW-1:QB];
            assign low_in = num[QB-1:0];
            assign den_in = den;
            assign q_in   = '0;
        end else begin : g_next
            assign rem_in = rem_reg[j-1];
            assign low_in = low_reg[j-1];
            assign den_in = den_reg[j-1];
            assign q_in   = q_reg[j-1];
        end

        always_comb begin
            trial = {rem_in, low_in[QB-1]};
            ge    = (trial >= {1'b0, den_in});
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[j] <= ge ? DW'(trial - {1'b0, den_in}) : DW'(trial);
                low_reg[j] <= {low_in[QB-2:0], 1'b0};
                den_reg[j] <= den_in;
                q_reg[j]   <= {q_in[QB-2:0], ge};
            end
        end
    end

    assign quo = q_reg[QB-1];
endmodule
`default_nettype wire

// ===== rtl/segment_intersection_unit.sv =====
// Segment intersection unit: top level with divider lanes and output register.
//
// Usage: one segment pair AB, CD is a transfer on the s_ channel (valid/ready);
// one result (m_hit, m_sx, m_sy) is a transfer on the m_ channel for each pair,
// in order. m_sx and m_sy are signed fixed point with FRAC_BITS fraction bits,
// truncated toward zero, and zero when m_hit is low.
// Pipeline from input transfer to m_valid: 4 front stages, 3 solve stages,
// one stage per quotient bit in both divider lanes, and the output register.
// Throughput: one pair per cycle unless the output stalls; every stage moves
// together on one enable.
// Stall: while m_valid is high and m_ready low the whole pipeline holds and
// s_ready is low; no item is lost or repeated.
// Reset: aresetn low at a clock edge clears all valid bits; the pipeline is
// empty and s_ready is high on the first cycle after reset.
`default_nettype none
module segment_intersection_unit #(
    parameter int COORD_BITS = sgi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = sgi_pkg::FRAC_BITS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [COORD_BITS-1:0]         s_ax,
    input  logic signed [COORD_BITS-1:0]         s_ay,
    input  logic signed [COORD_BITS-1:0]         s_bx,
    input  logic signed [COORD_BITS-1:0]         s_by_coord,
    input  logic signed [COORD_BITS-1:0]         s_cx,
    input  logic signed [COORD_BITS-1:0]         s_cy,
    input  logic signed [COORD_BITS-1:0]         s_dx,
    input  logic signed [COORD_BITS-1:0]         s_dy,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic                                 m_hit,
    output logic signed [sgi_pkg::OUT_BITS-1:0]  m_sx,
    output logic signed [sgi_pkg::OUT_BITS-1:0]  m_sy
);
    localparam int C   = COORD_BITS;
    localparam int OB  = sgi_pkg::OUT_BITS;
    localparam int DW  = 2 * C + 5;
    localparam int NW  = 3 * C + 8;
    localparam int GW  = 12 * C + 4;
    localparam int QB  = C + FRAC_BITS;
    localparam int QW  = ((QB > OB) ? QB : OB) + 1;
    localparam logic [QW-1:0] NEG_LIM = QW'(64'd1 << (OB - 1));
    localparam logic [QW-1:0] POS_LIM = NEG_LIM - QW'(1);

    logic                   en;
    logic                   f_valid, f_bad;
    logic signed [DW-1:0]   f_den, f_tn;
    logic [GW-1:0]          f_geo;
    logic                   v_valid, v_hit, v_neg_x, v_neg_y;
    logic [NW-1:0]          v_mag_x, v_mag_y;
    logic [DW-1:0]          v_den;
    logic [QB-1:0]          quo_x, quo_y;

    logic                   vld_reg   [QB];
    logic                   hit_reg   [QB];
    logic                   neg_x_reg [QB];
    logic                   neg_y_reg [QB];
    logic                   m_valid_reg, m_hit_reg;
    logic [OB-1:0]          m_sx_reg, m_sy_reg;

    function automatic logic [OB-1:0] to_out(input logic [QB-1:0] q, input logic neg);
        logic [QW-1:0] qe;
        logic [OB-1:0] res;
        qe = QW'(q);
        if (!neg && (qe > POS_LIM)) begin
            res = OB'(POS_LIM);
        end else if (neg && (qe > NEG_LIM)) begin
            res = OB'(NEG_LIM);
        end else if (neg) begin
            res = OB'(-qe);
        end else begin
            res = OB'(qe);
        end
        return res;
    endfunction

    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    sgi_front #(.COORD_BITS(COORD_BITS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (s_valid),
        .ax        (s_ax),
        .ay        (s_ay),
        .bx        (s_bx),
        .by_coord  (s_by_coord),
        .cx        (s_cx),
        .cy        (s_cy),
        .dx        (s_dx),
        .dy        (s_dy),
        .out_valid (f_valid),
        .out_bad   (f_bad),
        .den       (f_den),
        .tn        (f_tn),
        .geo       (f_geo)
    );

    sgi_solve #(.COORD_BITS(COORD_BITS)) u_solve (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (f_valid),
        .in_bad    (f_bad),
        .den       (f_den),
        .tn        (f_tn),
        .geo       (f_geo),
        .out_valid (v_valid),
        .out_hit   (v_hit),
        .out_neg_x (v_neg_x),
        .out_neg_y (v_neg_y),
        .out_mag_x (v_mag_x),
        .out_mag_y (v_mag_y),
        .out_den   (v_den)
    );

    sgi_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_x (
        .aclk (aclk),
        .en   (en),
        .mag  (v_mag_x),
        .den  (v_den),
        .quo  (quo_x)
    );

    sgi_div #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div_y (
        .aclk (aclk),
        .en   (en),
        .mag  (v_mag_y),
        .den  (v_den),
        .quo  (quo_y)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < QB; i++) begin
                vld_reg[i] <= 1'b0;
            end
            m_valid_reg <= 1'b0;
        end else if (en) begin
            vld_reg[0] <= v_valid;
            for (int i = 1; i < QB; i++) begin
                vld_reg[i] <= vld_reg[i-1];
            end
            m_valid_reg <= vld_reg[QB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            hit_reg[0]   <= v_hit;
            neg_x_reg[0] <= v_neg_x;
            neg_y_reg[0] <= v_neg_y;
            for (int i = 1; i < QB; i++) begin
                hit_reg[i]   <= hit_reg[i-1];
                neg_x_reg[i] <= neg_x_reg[i-1];
                neg_y_reg[i] <= neg_y_reg[i-1];
            end
            m_hit_reg <= hit_reg[QB-1];
            m_sx_reg  <= hit_reg[QB-1] ? to_out(quo_x, neg_x_reg[QB-1]) : '0;
            m_sy_reg  <= hit_reg[QB-1] ? to_out(quo_y, neg_y_reg[QB-1]) : '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_hit   = m_hit_reg;
    assign m_sx    = m_sx_reg;
    assign m_sy    = m_sy_reg;
endmodule
`default_nettype wire

// ===== rtl/sgi_check.sv =====
// Port checker for the segment intersection unit and its bind.
`default_nettype none
module sgi_check (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic                          m_hit,
    input logic [sgi_pkg::OUT_BITS-1:0]  m_sx,
    input logic [sgi_pkg::OUT_BITS-1:0]  m_sy
);
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid after reset");

    a_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_hit |-> (m_sx == '0) && (m_sy == '0))
        else $error("nonzero point without hit");

    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid || m_ready) |-> s_ready)
        else $error("input stalled while output free");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_hit) && $stable(m_sx) && $stable(m_sy))
        else $error("stalled result changed");
endmodule

bind segment_intersection_unit sgi_check u_sgi_check (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_hit   (m_hit),
    .m_sx    (m_sx),
    .m_sy    (m_sy)
);
`default_nettype wire
